[sv/vn_pkg.sv]
// Shared types and constants for the vector normalize block.
// Depends on nothing; every other file imports it.
package vn_pkg;

  localparam int unsigned COMP_W     = 32;
  localparam int unsigned SQR_W      = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned REM_W      = 34;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned NUM_COMP   = 3;

  // One input transaction: three signed Q16.16 components.
  typedef struct packed {
    logic signed [COMP_W-1:0] in_x;
    logic signed [COMP_W-1:0] in_y;
    logic signed [COMP_W-1:0] in_z;
  } vn_in_t;

  // One output transaction: Q2.30 unit vector, Q16.16 length and zero flag.
  typedef struct packed {
    logic signed [COMP_W-1:0] unit_x;
    logic signed [COMP_W-1:0] unit_y;
    logic signed [COMP_W-1:0] unit_z;
    logic [COMP_W-1:0]        vec_length;
    logic                     zero_vector;
  } vn_out_t;

endpackage

[sv/vn_div_lane.sv]
// One pipelined restoring divider lane: (mag << 30) / len, one quotient bit per stage.
// Depends on vn_pkg.
module vn_div_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vn_pkg::COMP_W-1:0]  mag,
  input  logic [vn_pkg::COMP_W-1:0]  len,
  output logic [vn_pkg::DIV_STEPS-1:0] quot
);
  import vn_pkg::*;

  logic [COMP_W-1:0]    rem  [DIV_STEPS];
  logic [DIV_STEPS-1:0] qbit [DIV_STEPS];
  logic [COMP_W-1:0]    dlen [DIV_STEPS];

  genvar j;
  generate
    for (j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [COMP_W-1:0]    prev_rem;
      logic [DIV_STEPS-1:0] prev_q;
      logic [COMP_W-1:0]    prev_len;
      logic                 bit_in;
      logic [COMP_W:0]      shifted;
      logic [COMP_W:0]      diff;

      // The first step starts from the top bits of the magnitude; the rest shift in zeros.
      if (j == 0) begin : g_first
        assign prev_rem = {1'b0, mag[COMP_W-1:1]};
        assign prev_q   = '0;
        assign prev_len = len;
        assign bit_in   = mag[0];
      end else begin : g_rest
        assign prev_rem = rem[j-1];
        assign prev_q   = qbit[j-1];
        assign prev_len = dlen[j-1];
        assign bit_in   = 1'b0;
      end

      // Trial subtraction of the divisor from the shifted remainder.
      always_comb begin
        shifted = {prev_rem, bit_in};
        diff    = shifted - {1'b0, prev_len};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dlen[j] <= prev_len;
          if (shifted >= {1'b0, prev_len}) begin
            rem[j]  <= diff[COMP_W-1:0];
            qbit[j] <= {prev_q[DIV_STEPS-2:0], 1'b1};
          end else begin
            rem[j]  <= shifted[COMP_W-1:0];
            qbit[j] <= {prev_q[DIV_STEPS-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign quot = qbit[DIV_STEPS-1];

endmodule

[sv/vector_normalize.sv]
// Top level of the vector normalize block: magnitude, square, sum, square root and divide.
// Depends on vn_pkg and vn_div_lane.

// Normalizes one 3D vector of signed Q16.16 components per transaction into a signed
// Q2.30 unit vector, plus the rounded-down Q16.16 length and a flag for the zero vector
// (whose unit components read as zero). The block accepts one transaction every cycle
// while in_stall is low. The pipeline runs through registers for magnitude, squaring and
// summing, 32 square-root stages that each resolve one root bit, 31 divider stages that
// each resolve one quotient bit, and the output register. A one-entry input skid register
// lets the block take a transaction in the cycle the output is stalled; in_stall follows
// it.
module vector_normalize (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  vn_pkg::vn_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output vn_pkg::vn_out_t out_data
);
  import vn_pkg::*;

  logic   adv;
  logic   skid_full;
  vn_in_t skid;
  logic   ent_valid;
  vn_in_t ent_data;

  // Whole pipeline moves unless a finished result is held at the output.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = skid_full;

  // Input skid register catches a transaction taken while the pipeline is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (adv) begin
      skid_full <= 1'b0;
    end else if (in_valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && !skid_full) begin
      skid <= in_data;
    end
  end

  always_comb begin
    ent_valid = skid_full || in_valid;
    ent_data  = skid_full ? skid : in_data;
  end

  // Stage 0: magnitudes and signs.
  logic                            v0;
  logic [NUM_COMP-1:0][COMP_W-1:0] m0;
  logic [NUM_COMP-1:0]             n0;
  logic [NUM_COMP-1:0][COMP_W-1:0] comp_in;

  // Index 0 is x, 1 is y, 2 is z.
  assign comp_in = {ent_data.in_z, ent_data.in_y, ent_data.in_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= ent_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        n0[c] <= comp_in[c][COMP_W-1];
        m0[c] <= comp_in[c][COMP_W-1] ? (~comp_in[c] + 1'b1) : comp_in[c];
      end
    end
  end

  // Stage 1: one 32 by 32 square per component.
  logic                            v1;
  logic [NUM_COMP-1:0][SQR_W-1:0]  sq1;
  logic [NUM_COMP-1:0][COMP_W-1:0] m1;
  logic [NUM_COMP-1:0]             n1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1 <= m0;
      n1 <= n0;
      for (int c = 0; c < NUM_COMP; c++) begin
        sq1[c] <= SQR_W'(m0[c]) * SQR_W'(m0[c]);
      end
    end
  end

  // Stage 2: sum of squares, exact in 64 bits.
  logic                            v2;
  logic [SQR_W-1:0]                sum2;
  logic [NUM_COMP-1:0][COMP_W-1:0] m2;
  logic [NUM_COMP-1:0]             n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2   <= m1;
      n2   <= n1;
      sum2 <= sq1[0] + sq1[1] + sq1[2];
    end
  end

  // Square root stages: each takes two radicand bits and resolves one root bit.
  logic                            sq_valid [SQRT_STEPS];
  logic [REM_W-1:0]                sq_rem   [SQRT_STEPS];
  logic [COMP_W-1:0]               sq_root  [SQRT_STEPS];
  logic [SQR_W-1:0]                sq_v     [SQRT_STEPS];
  logic [NUM_COMP-1:0][COMP_W-1:0] sq_mag   [SQRT_STEPS];
  logic [NUM_COMP-1:0]             sq_neg   [SQRT_STEPS];

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic                            p_valid;
      logic [REM_W-1:0]                p_rem;
      logic [COMP_W-1:0]               p_root;
      logic [SQR_W-1:0]                p_v;
      logic [NUM_COMP-1:0][COMP_W-1:0] p_mag;
      logic [NUM_COMP-1:0]             p_neg;
      logic [REM_W+1:0]                rem_try;
      logic [REM_W+1:0]                trial;
      logic [REM_W+1:0]                diff;

      if (k == 0) begin : g_first
        assign p_valid = v2;
        assign p_rem   = '0;
        assign p_root  = '0;
        assign p_v     = sum2;
        assign p_mag   = m2;
        assign p_neg   = n2;
      end else begin : g_rest
        assign p_valid = sq_valid[k-1];
        assign p_rem   = sq_rem[k-1];
        assign p_root  = sq_root[k-1];
        assign p_v     = sq_v[k-1];
        assign p_mag   = sq_mag[k-1];
        assign p_neg   = sq_neg[k-1];
      end

      // Compare the partial remainder against 4*root + 1.
      always_comb begin
        rem_try = {p_rem, p_v[SQR_W-1:SQR_W-2]};
        trial   = {2'b00, p_root, 2'b01};
        diff    = rem_try - trial;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          sq_valid[k] <= 1'b0;
        end else if (adv) begin
          sq_valid[k] <= p_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          sq_v[k]   <= {p_v[SQR_W-3:0], 2'b00};
          sq_mag[k] <= p_mag;
          sq_neg[k] <= p_neg;
          if (rem_try >= trial) begin
            sq_rem[k]  <= diff[REM_W-1:0];
            sq_root[k] <= {p_root[COMP_W-2:0], 1'b1};
          end else begin
            sq_rem[k]  <= rem_try[REM_W-1:0];
            sq_root[k] <= {p_root[COMP_W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // Divider stages: the lanes hold the arithmetic, this side carries control and sidebands.
  logic                [NUM_COMP-1:0][DIV_STEPS-1:0] quot;
  logic                dv_valid [DIV_STEPS];
  logic [COMP_W-1:0]   dv_len   [DIV_STEPS];
  logic [NUM_COMP-1:0] dv_neg   [DIV_STEPS];

  genvar c;
  generate
    for (c = 0; c < NUM_COMP; c++) begin : g_lane
      vn_div_lane u_lane (
        .clk  (clk),
        .en   (adv),
        .mag  (sq_mag[SQRT_STEPS-1][c]),
        .len  (sq_root[SQRT_STEPS-1]),
        .quot (quot[c])
      );
    end
  endgenerate

  genvar d;
  generate
    for (d = 0; d < DIV_STEPS; d++) begin : g_side
      logic                p_valid;
      logic [COMP_W-1:0]   p_len;
      logic [NUM_COMP-1:0] p_neg;

      if (d == 0) begin : g_first
        assign p_valid = sq_valid[SQRT_STEPS-1];
        assign p_len   = sq_root[SQRT_STEPS-1];
        assign p_neg   = sq_neg[SQRT_STEPS-1];
      end else begin : g_rest
        assign p_valid = dv_valid[d-1];
        assign p_len   = dv_len[d-1];
        assign p_neg   = dv_neg[d-1];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          dv_valid[d] <= 1'b0;
        end else if (adv) begin
          dv_valid[d] <= p_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_len[d] <= p_len;
          dv_neg[d] <= p_neg;
        end
      end
    end
  endgenerate

  // Output register: apply signs, force zero components for a zero-length vector.
  logic                            last_zero;
  logic [NUM_COMP-1:0][COMP_W-1:0] unit_next;

  always_comb begin
    last_zero = (dv_len[DIV_STEPS-1] == '0);
    for (int i = 0; i < NUM_COMP; i++) begin
      if (last_zero) begin
        unit_next[i] = '0;
      end else if (dv_neg[DIV_STEPS-1][i]) begin
        unit_next[i] = COMP_W'(~{1'b0, quot[i]} + 1'b1);
      end else begin
        unit_next[i] = COMP_W'(quot[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.unit_x      <= unit_next[0];
      out_data.unit_y      <= unit_next[1];
      out_data.unit_z      <= unit_next[2];
      out_data.vec_length  <= dv_len[DIV_STEPS-1];
      out_data.zero_vector <= last_zero;
    end
  end

endmodule
